// ----- design/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared command type, action and status codes, and fixed field widths.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Entry store size and entry width; the port widths above are built for these.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // Action codes carried on s_tuser.
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WALK_FWD   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_WALK_BWD   = 3'd5;

    // Result status codes carried on m_tuser.
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

    // Command kinds after decode.
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_WALK = 2'd2;

    // Depth of the command queue between decode and execution.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = 1;

    typedef struct packed {
        logic [1:0]         kind;
        logic               rear;   // back end for push/pop, reverse order for walk
        logic [VALUE_W-1:0] value;
    } cmd_t;

endpackage

// ----- design/deq_front.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue front end
// Accepts input transfers, decodes the action and forwards a command.
// ----------------------------------------------------------------------------
module deq_front
    import deq_pkg::*;
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,
    input  logic [ACTION_W-1:0] s_tuser,
    output logic                q_valid,
    input  logic                q_ready,
    output cmd_t                q_cmd
);

    logic known;

    always_comb begin
        known       = 1'b1;
        q_cmd.value = s_tdata;
        q_cmd.kind  = CMD_PUSH;
        q_cmd.rear  = 1'b0;
        case (s_tuser)
            ACT_PUSH_FRONT: begin
                q_cmd.kind = CMD_PUSH;
            end
            ACT_PUSH_BACK: begin
                q_cmd.kind = CMD_PUSH;
                q_cmd.rear = 1'b1;
            end
            ACT_POP_FRONT: begin
                q_cmd.kind = CMD_POP;
            end
            ACT_POP_BACK: begin
                q_cmd.kind = CMD_POP;
                q_cmd.rear = 1'b1;
            end
            ACT_WALK_FWD: begin
                q_cmd.kind = CMD_WALK;
            end
            ACT_WALK_BWD: begin
                q_cmd.kind = CMD_WALK;
                q_cmd.rear = 1'b1;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Unknown actions are taken and discarded without reaching the queue.
    assign s_tready = q_ready || !known;
    assign q_valid  = s_tvalid && known;

endmodule

// ----- design/deq_queue.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue command FIFO
// Short FIFO that decouples command decode from execution.
// ----------------------------------------------------------------------------
module deq_queue
    import deq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_cmd
);

    cmd_t                  slot_mem [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PW:0]     fill_reg, fill_next;
    logic                  do_wr, do_rd;

    assign wr_ready = fill_reg != (QUEUE_PW+1)'(QUEUE_DEPTH);
    assign rd_valid = fill_reg != '0;
    assign rd_cmd   = slot_mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr && !do_rd) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ----- design/deq_back.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue back end
// Holds the circular entry store, executes commands and drives results.
// ----------------------------------------------------------------------------
module deq_back
    import deq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  cmd_t                cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STATUS_W-1:0] out_status,
    output logic [VALUE_W-1:0]  out_data,
    output logic                out_last,
    output logic [COUNT_W-1:0]  out_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEPTH_W = (PW+1)'(DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                  state_reg, state_next;
    logic [PW-1:0]         front_reg, front_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [PW-1:0]         walk_idx_reg, walk_idx_next;
    logic                  walk_reg, walk_next;
    logic                  rear_reg, rear_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [VALUE_W-1:0]    out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    logic [DATA_WIDTH-1:0] entry_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                  out_free, take, full, empty, walk_done;
    logic [CW-1:0]         cnt_dec;
    logic [PW-1:0]         walk_step;
    logic [PW-1:0]         rd_off;
    logic                  rd_en, wr_en;
    logic [PW-1:0]         rd_addr, wr_addr;

    // Slot of the entry at a given offset from the front, wrapped once.
    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                              input logic [PW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[PW-1:0];
    endfunction

    assign out_free  = !out_valid_reg || m_tready;
    assign cmd_ready = (state_reg == ST_IDLE) && out_free;
    assign take      = cmd_valid && cmd_ready;
    assign full      = count_reg == FULL_CNT;
    assign empty     = count_reg == '0;
    assign cnt_dec   = count_reg - CW'(1);
    assign walk_done = !walk_reg || (walk_idx_reg == cnt_dec[PW-1:0]);
    assign walk_step = walk_idx_reg + PW'(1);
    assign rd_addr   = slot_of(front_reg, rd_off);

    always_comb begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        walk_idx_next   = walk_idx_reg;
        walk_next       = walk_reg;
        rear_next       = rear_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        rd_en           = 1'b0;
        rd_off          = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;

        case (state_reg)
            ST_IDLE: begin
                // A pop from the back and a reverse walk both start at the last entry.
                rd_off = cmd.rear ? cnt_dec[PW-1:0] : '0;
                if (take) begin
                    out_data_next = '0;
                    out_last_next = 1'b1;
                    case (cmd.kind)
                        CMD_PUSH: begin
                            out_valid_next = 1'b1;
                            if (full) begin
                                out_status_next = STS_FULL;
                                out_count_next  = COUNT_W'(count_reg);
                            end else begin
                                wr_en = 1'b1;
                                if (cmd.rear) begin
                                    wr_addr = slot_of(front_reg, count_reg[PW-1:0]);
                                end else begin
                                    wr_addr = (front_reg == '0) ? LAST_SLOT
                                                                : front_reg - PW'(1);
                                    front_next = wr_addr;
                                end
                                count_next      = count_reg + CW'(1);
                                out_status_next = STS_OK;
                                out_count_next  = COUNT_W'(count_reg + CW'(1));
                            end
                        end
                        CMD_POP, CMD_WALK: begin
                            if (empty) begin
                                out_valid_next  = 1'b1;
                                out_status_next = STS_EMPTY;
                                out_count_next  = COUNT_W'(count_reg);
                            end else begin
                                rd_en         = 1'b1;
                                walk_idx_next = '0;
                                rear_next     = cmd.rear;
                                state_next    = ST_READ;
                                if (cmd.kind == CMD_POP) begin
                                    walk_next  = 1'b0;
                                    count_next = cnt_dec;
                                    if (!cmd.rear) begin
                                        front_next = (front_reg == LAST_SLOT) ? '0
                                                     : front_reg + PW'(1);
                                    end
                                end else begin
                                    walk_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                            out_valid_next = out_valid_reg && !m_tready;
                        end
                    endcase
                end
            end
            ST_READ: begin
                rd_off = rear_reg ? (cnt_dec[PW-1:0] - walk_step) : walk_step;
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = STS_OK;
                    out_data_next   = VALUE_W'(rd_data_reg);
                    out_last_next   = walk_done;
                    out_count_next  = COUNT_W'(count_reg);
                    if (walk_done) begin
                        state_next = ST_IDLE;
                    end else begin
                        // Fetch the next entry while this one is presented.
                        rd_en         = 1'b1;
                        walk_idx_next = walk_step;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            walk_idx_reg  <= '0;
            walk_reg      <= 1'b0;
            rear_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            walk_idx_reg  <= walk_idx_next;
            walk_reg      <= walk_next;
            rear_reg      <= rear_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= DATA_WIDTH'(cmd.value);
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign out_last   = out_last_reg;
    assign out_count  = out_count_reg;

endmodule

// ----- design/double_ended_queue.sv -----
// A push or an empty-status result passes the command queue and the output register;
// a pop or a walk also passes the single registered read port of the entry store.
// Throughput: one push per cycle while m_tready takes results; a pop or a walk holds
// the back end in ST_READ, which takes no new command, until its last entry is out.
// Reset clears the front pointer, the entry count and the command queue; store contents
// are left as they are and only written entries are ever read.
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque in a circular store with push, pop and walk at either end.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // value[31:0]
    input  logic [2:0]          s_tuser,   // action[2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // data[31:0], entry_count[36:32], zero[39:37]
    output logic [1:0]          m_tuser,   // status[1:0]
    output logic                m_tlast
);

    logic                q_in_valid, q_in_ready;
    cmd_t                q_in_cmd;
    logic                q_out_valid, q_out_ready;
    cmd_t                q_out_cmd;
    logic [VALUE_W-1:0]  res_data;
    logic [COUNT_W-1:0]  res_count;

    deq_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_cmd    (q_in_cmd)
    );

    deq_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_cmd   (q_in_cmd),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_cmd   (q_out_cmd)
    );

    deq_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (q_out_valid),
        .cmd_ready  (q_out_ready),
        .cmd        (q_out_cmd),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (m_tuser),
        .out_data   (res_data),
        .out_last   (m_tlast),
        .out_count  (res_count)
    );

    assign m_tdata = {3'b000, res_count, res_data};

endmodule
